FILE: sv/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decoder package
// Shared sizes for the LZSS byte decoder.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  localparam int HistoryDepth = 4096;   // history window in bytes
  localparam int MaxMatch     = 16;     // longest copy of one match token
  localparam int LenW         = $clog2(MaxMatch);
  localparam int DistW        = 12;     // distance field of a match token

endpackage

FILE: sv/lzss_byte_decoder.sv
// ----------------------------------------------------------------------------
// LZSS byte decoder
// Decodes an LZSS stream with a 4 KiB history window, one byte per word.
// ----------------------------------------------------------------------------
// One compressed byte enters per input word. A flag byte gives eight token
// bits, LSB first; a 0 token is a literal byte, a 1 token a two-byte match
// (12-bit distance minus one, then a nibble of length minus one). A length
// nibble of zero ends the stream: one word with end_of_stream set comes out
// and the next byte is taken as a flag byte. A second match byte of length L
// blocks the input while the copy engine streams bytes out of the history
// RAM, one per cycle while the output has room: a read is issued and its data
// is written back at the next cycle, so overlapping copies forward the byte
// being written. The output side is a two-word FIFO, so a stalled sink
// stops the copy engine without losing a byte. History RAM contents are not
// cleared.
// ----------------------------------------------------------------------------
module lzss_byte_decoder
  import lzsd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistoryDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // last_of_run
  output logic [1:0] m_axis_tuser    // [0] byte_valid, [1] end_of_stream
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    PH_FLAG      = 2'd0,
    PH_TOKEN     = 2'd1,
    PH_MATCH_LOW = 2'd2
  } phase_e;

  // output FIFO entry
  typedef struct packed {
    logic       eos;
    logic       last;
    logic       valid;
    logic [7:0] data;
  } res_t;

  // parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [2:0]  tokens_q, tokens_d;
  logic [7:0]  ofs_hi_q, ofs_hi_d;
  logic [AW-1:0] wp_q, wp_d;

  // copy engine
  logic          busy_q, busy_d;
  logic [AW-1:0] src_q, src_d;
  logic [LenW-1:0] rem_q, rem_d;     // bytes left to read, minus one
  logic          infl_q;             // read data returns this cycle
  logic          infl_last_q;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;

  // output FIFO
  res_t       fifo_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  logic          in_acc, pop, push, issue;
  res_t          push_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata, ret_data;
  logic [DistW-1:0] back_ofs;
  logic [2:0]    occ;

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign ret_data = fwd_q ? fwd_data_q : ram_rdata;
  assign occ      = {1'b0, cnt_q} + {2'b00, infl_q} - {2'b00, pop};
  assign issue    = busy_q && (occ < 3'd2);

  assign s_axis_tready = !busy_q && !infl_q && (cnt_q != 2'd2);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign back_ofs = {ofs_hi_q, s_axis_tdata[7:4]};

  always_comb begin
    phase_d   = phase_q;
    flags_d   = flags_q;
    tokens_d  = tokens_q;
    ofs_hi_d  = ofs_hi_q;
    wp_d      = wp_q;
    busy_d    = busy_q;
    src_d     = src_q;
    rem_d     = rem_q;
    push      = 1'b0;
    push_res  = '0;
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = s_axis_tdata;

    // copy data coming back from the RAM: append to history and emit
    if (infl_q) begin
      ram_we    = 1'b1;
      ram_wdata = ret_data;
      wp_d      = wp_q + 1'b1;
      push      = 1'b1;
      push_res  = '{eos: 1'b0, last: infl_last_q, valid: 1'b1, data: ret_data};
    end

    if (issue) begin
      src_d = src_q + 1'b1;
      rem_d = rem_q - 1'b1;
      if (rem_q == '0) begin
        busy_d = 1'b0;
      end
    end

    if (in_acc) begin
      case (phase_q)
        PH_TOKEN: begin
          if (flags_q[0]) begin
            ofs_hi_d = s_axis_tdata;
            phase_d  = PH_MATCH_LOW;
          end else begin
            ram_we   = 1'b1;
            wp_d     = wp_q + 1'b1;
            push     = 1'b1;
            push_res = '{eos: 1'b0, last: 1'b1, valid: 1'b1, data: s_axis_tdata};
          end
        end
        PH_MATCH_LOW: begin
          if (s_axis_tdata[3:0] == 4'd0) begin
            push     = 1'b1;
            push_res = '{eos: 1'b1, last: 1'b1, valid: 1'b0, data: 8'd0};
            flags_d  = '0;
            tokens_d = '0;
            phase_d  = PH_FLAG;
          end else begin
            busy_d = 1'b1;
            src_d  = wp_q - AW'(back_ofs) - 1'b1;
            rem_d  = LenW'(s_axis_tdata[3:0]);
          end
        end
        default: begin
          flags_d  = s_axis_tdata;
          tokens_d = 3'd7;
          phase_d  = PH_TOKEN;
        end
      endcase

      // token finished: literal, or a match that is not the stream end
      if ((phase_q == PH_TOKEN && !flags_q[0]) ||
          (phase_q == PH_MATCH_LOW && s_axis_tdata[3:0] != 4'd0)) begin
        if (tokens_q == 3'd0) begin
          phase_d = PH_FLAG;
        end else begin
          tokens_d = tokens_q - 1'b1;
          flags_d  = {1'b0, flags_q[7:1]};
          phase_d  = PH_TOKEN;
        end
      end
    end

    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  lzsd_ram #(
    .Width(8),
    .Depth(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (issue),
    .raddr_i(src_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FLAG;
      flags_q     <= '0;
      tokens_q    <= '0;
      ofs_hi_q    <= '0;
      wp_q        <= '0;
      busy_q      <= 1'b0;
      rem_q       <= '0;
      infl_q      <= 1'b0;
      infl_last_q <= 1'b0;
      fwd_q       <= 1'b0;
      rd_ptr_q    <= 1'b0;
      wr_ptr_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      tokens_q    <= tokens_d;
      ofs_hi_q    <= ofs_hi_d;
      wp_q        <= wp_d;
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      infl_q      <= issue;
      infl_last_q <= issue && (rem_q == '0);
      // the RAM reads old data when the address is written in the same cycle
      fwd_q       <= issue && ram_we && (src_q == ram_waddr);
      cnt_q       <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    fwd_data_q <= ram_wdata;
    if (push) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].data;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;
  assign m_axis_tuser  = {fifo_q[rd_ptr_q].eos, fifo_q[rd_ptr_q].valid};

endmodule

FILE: sv/lzsd_ram.sv
// ----------------------------------------------------------------------------
// LZSS decoder RAM
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
